@@ hdl/fdd_pkg.sv @@
package fdd_pkg;

    // Width of the mode register.
    localparam int MODE_W = 2;

    // Mode register codes. The code left over behaves as MODE_ZERO.
    localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_FIRST;

    // Request from the sequencer to the serial divider.
    typedef struct packed {
        logic start;
        logic squared;
    } t_div_ctl;

    // Status from the serial divider back to the sequencer.
    typedef struct packed {
        logic done;
        logic zero;
    } t_div_sts;

endpackage

@@ hdl/fdd_div.sv @@
module fdd_div #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fdd_pkg::t_div_ctl          i_ctl,
    input  logic [VALUE_WIDTH+1:0]     i_num,
    input  logic [VALUE_WIDTH:0]       i_den,
    output fdd_pkg::t_div_sts          o_sts,
    output logic [VALUE_WIDTH-1:0]     o_quot
);

    localparam int NUM_W    = VALUE_WIDTH + 2;
    localparam int NMAG_W   = VALUE_WIDTH + 1;
    localparam int DEN_W    = VALUE_WIDTH + 1;
    localparam int REM_W    = VALUE_WIDTH;
    localparam int BITS_MAX = NMAG_W + 2 * FRACTION_BITS;
    localparam int CNT_W    = $clog2(BITS_MAX + 1);

    localparam logic [CNT_W-1:0] CNT_FD = CNT_W'(NMAG_W + FRACTION_BITS);
    localparam logic [CNT_W-1:0] CNT_SQ = CNT_W'(NMAG_W + 2 * FRACTION_BITS);

    localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic                   r_done;
    logic                   r_q1v;
    logic [NMAG_W-1:0]      r_nsr;
    logic [DEN_W-1:0]       r_dmag;
    logic [REM_W-1:0]       r_rem1;
    logic [REM_W-1:0]       r_rem2;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_q;
    logic                   r_ovf;
    logic                   r_q1bit;
    logic                   r_sq;
    logic                   r_neg;
    logic                   r_zero;
    logic [VALUE_WIDTH-1:0] r_quot;

    logic [NUM_W-1:0]       num_abs;
    logic [DEN_W-1:0]       den_abs;
    logic [DEN_W-1:0]       t1;
    logic [DEN_W-1:0]       t2;
    logic [DEN_W-1:0]       d1;
    logic [DEN_W-1:0]       d2;
    logic                   ge1;
    logic                   ge2;
    logic                   step1;
    logic                   push_en;
    logic                   push_bit;
    logic [VALUE_WIDTH-1:0] q_final;

    // Magnitudes of the operands, taken as the division starts.
    assign num_abs = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
    assign den_abs = i_den[DEN_W-1] ? (~i_den + DEN_W'(1)) : i_den;

    // First restoring stage: one numerator bit per cycle.
    assign t1    = {r_rem1, r_nsr[NMAG_W-1]};
    assign ge1   = (t1 >= r_dmag);
    assign d1    = t1 - r_dmag;
    assign step1 = (r_cnt != '0);

    // Second restoring stage: consumes the first stage's quotient bits in the cycle after they are produced.
    assign t2  = {r_rem2, r_q1bit};
    assign ge2 = (t2 >= r_dmag);
    assign d2  = t2 - r_dmag;

    // The final quotient comes from the second stage for a squared divisor.
    assign push_en  = r_sq ? r_q1v : step1;
    assign push_bit = r_sq ? ge2 : ge1;

    // Saturation and sign of the finished quotient; a zero divisor gives a zero quotient.
    always_comb begin
        if (r_zero) begin
            q_final = '0;
        end else if (!r_neg) begin
            q_final = (r_ovf || r_q[VALUE_WIDTH-1]) ? MAX_POS : r_q;
        end else if (r_ovf || (r_q[VALUE_WIDTH-1] && (|r_q[VALUE_WIDTH-2:0]))) begin
            q_final = MIN_NEG;
        end else begin
            q_final = ~r_q + VALUE_WIDTH'(1);
        end
    end

    // Next state of the divider sequence.
    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (den_abs == '0) ? D_FIN : D_RUN;
                end
            end
            D_RUN: begin
                if (!step1 && (!r_sq || !r_q1v)) begin
                    n_state = D_FIN;
                end
            end
            D_FIN: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_q1v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_FIN);
            if (r_state == D_IDLE) begin
                r_q1v <= 1'b0;
            end else if (r_state == D_RUN) begin
                r_q1v <= step1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_ctl.start) begin
                    r_nsr  <= num_abs[NMAG_W-1:0];
                    r_dmag <= den_abs;
                    r_rem1 <= '0;
                    r_rem2 <= '0;
                    r_cnt  <= i_ctl.squared ? CNT_SQ : CNT_FD;
                    r_q    <= '0;
                    r_ovf  <= 1'b0;
                    r_sq   <= i_ctl.squared;
                    r_neg  <= i_ctl.squared ? i_num[NUM_W-1]
                                            : (i_num[NUM_W-1] ^ i_den[DEN_W-1]);
                    r_zero <= (den_abs == '0);
                end
            end
            D_RUN: begin
                if (step1) begin
                    r_rem1  <= ge1 ? d1[REM_W-1:0] : t1[REM_W-1:0];
                    r_nsr   <= {r_nsr[NMAG_W-2:0], 1'b0};
                    r_cnt   <= r_cnt - CNT_W'(1);
                    r_q1bit <= ge1;
                end
                if (r_sq && r_q1v) begin
                    r_rem2 <= ge2 ? d2[REM_W-1:0] : t2[REM_W-1:0];
                end
                if (push_en) begin
                    r_q   <= {r_q[VALUE_WIDTH-2:0], push_bit};
                    r_ovf <= r_ovf | r_q[VALUE_WIDTH-1];
                end
            end
            D_FIN: begin
                r_quot <= q_final;
            end
            default: begin
                r_quot <= r_quot;
            end
        endcase
    end

    assign o_sts.done = r_done;
    assign o_sts.zero = r_zero;
    assign o_quot     = r_quot;

endmodule

@@ hdl/fdd_out_stage.sv @@
module fdd_out_stage #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [VALUE_WIDTH-1:0] i_derivative,
    input  logic                   i_last,
    input  logic                   i_zero,
    output logic                   o_free,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_derivative,
    output logic                   o_last_result,
    output logic                   o_zero_divisor
);

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_derivative;
    logic                   r_last;
    logic                   r_zero;
    logic                   take;

    // The register can take a new item when empty or when its item leaves this cycle.
    assign o_free = !r_valid || !i_stall;
    assign take   = i_load && o_free;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Held result.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_derivative <= i_derivative;
            r_last       <= i_last;
            r_zero       <= i_zero;
        end
    end

    assign o_valid        = r_valid;
    assign o_derivative   = r_derivative;
    assign o_last_result  = r_last;
    assign o_zero_divisor = r_zero;

endmodule

@@ hdl/finite_difference_derivative_line_top.sv @@
// One item at a time: o_stall is high from acceptance until all of an item's results are issued.
// A division runs one bit per cycle, over more quotient bits in mode 2 than in mode 1; each extra
// copy of a result adds an emit, a mode 1 line end adds a second division for the backward
// difference, and items with no division skip the divider. Output stalls hold the sequencer
// in its emit state, so they lengthen every item that has a result to issue.
// Synchronous active-low reset clears history, the sample count and the output; mode resets to 1.
module finite_difference_derivative_line_top #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fdd_pkg::MODE_W-1:0]          i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [VALUE_WIDTH-1:0]       i_sample_value,
    input  logic signed [VALUE_WIDTH-1:0]       i_coordinate,
    input  logic                                i_line_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [VALUE_WIDTH-1:0]       o_derivative,
    output logic                                o_last_result,
    output logic                                o_zero_divisor
);

    localparam int NUM_W = VALUE_WIDTH + 2;
    localparam int DEN_W = VALUE_WIDTH + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [fdd_pkg::MODE_W-1:0] r_mode;
    logic [1:0]                 r_seen;
    logic [VALUE_WIDTH-1:0]     r_pv0;
    logic [VALUE_WIDTH-1:0]     r_pv1;
    logic [VALUE_WIDTH-1:0]     r_pc0;
    logic [VALUE_WIDTH-1:0]     r_pc1;

    logic [VALUE_WIDTH-1:0]     r_v;
    logic [VALUE_WIDTH-1:0]     r_c;
    logic                       r_end;
    logic                       r_live;
    logic [1:0]                 r_copies;
    logic                       r_last_fin;
    logic                       r_has_b;
    logic                       r_use_div;
    logic                       r_sq;
    logic                       r_sel1;
    logic [NUM_W-1:0]           r_num;
    logic [DEN_W-1:0]           r_den;
    logic [VALUE_WIDTH-1:0]     r_res;
    logic                       r_zf;

    logic                       accept;
    logic                       a_live;
    logic [1:0]                 a_copies;
    logic                       a_last_fin;
    logic                       a_has_b;
    logic                       a_use_div;
    logic                       a_sq;
    logic                       a_sel1;

    logic [NUM_W-1:0]           v_x;
    logic [NUM_W-1:0]           p0_x;
    logic [NUM_W-1:0]           p1_x;
    logic [NUM_W-1:0]           p0_2x;
    logic [NUM_W-1:0]           num_n;
    logic [DEN_W-1:0]           den_n;

    fdd_pkg::t_div_ctl          div_ctl;
    fdd_pkg::t_div_sts          div_sts;
    logic [VALUE_WIDTH-1:0]     div_quot;
    logic                       out_free;
    logic                       emit_load;
    logic                       emit_last;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // Work plan of an item, decided from the mode, the line-end flag and the samples seen so far in the line.
    always_comb begin
        a_live     = (r_mode == fdd_pkg::MODE_FIRST);
        a_copies   = 2'd0;
        a_last_fin = 1'b1;
        a_has_b    = 1'b0;
        a_use_div  = 1'b0;
        a_sq       = 1'b0;
        a_sel1     = 1'b0;
        if (r_mode == fdd_pkg::MODE_SECOND) begin
            if (r_seen < 2'd2) begin
                // Too short so far: zeros only, and only at a line end.
                if (i_line_end) begin
                    a_copies = (r_seen == 2'd1) ? 2'd2 : 2'd1;
                end
            end else begin
                a_use_div  = 1'b1;
                a_sq       = 1'b1;
                a_copies   = ((r_seen == 2'd2) ? 2'd2 : 2'd1) + {1'b0, i_line_end};
                a_last_fin = i_line_end;
            end
        end else if (r_seen == 2'd0) begin
            a_copies = i_line_end ? 2'd1 : 2'd0;
        end else begin
            // Forward difference for the first point, central differences after it.
            a_use_div  = a_live;
            a_sel1     = (r_seen != 2'd1);
            a_copies   = 2'd1;
            a_last_fin = 1'b0;
            a_has_b    = i_line_end;
        end
    end

    // Numerator and spacing of the pending division.
    assign v_x   = {{2{r_v[VALUE_WIDTH-1]}}, r_v};
    assign p0_x  = {{2{r_pv0[VALUE_WIDTH-1]}}, r_pv0};
    assign p1_x  = {{2{r_pv1[VALUE_WIDTH-1]}}, r_pv1};
    assign p0_2x = {r_pv0[VALUE_WIDTH-1], r_pv0, 1'b0};
    assign num_n = r_sq ? (v_x - p0_2x + p1_x) : (v_x - (r_sel1 ? p1_x : p0_x));
    assign den_n = {r_c[VALUE_WIDTH-1], r_c}
                 - (r_sel1 ? {r_pc1[VALUE_WIDTH-1], r_pc1} : {r_pc0[VALUE_WIDTH-1], r_pc0});

    assign div_ctl.start   = (r_state == S_START);
    assign div_ctl.squared = r_sq;

    assign emit_load = (r_state == S_EMIT) && out_free;
    assign emit_last = r_last_fin && (r_copies == 2'd1);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_copies == 2'd0) begin
                    n_state = S_DONE;
                end else if (r_use_div) begin
                    n_state = S_START;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_sts.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free && (r_copies == 2'd1)) begin
                    n_state = r_has_b ? S_PREP : S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, mode register and line history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= fdd_pkg::MODE_RESET;
            r_seen  <= 2'd0;
            r_pv0   <= '0;
            r_pv1   <= '0;
            r_pc0   <= '0;
            r_pc1   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (r_state == S_DONE) begin
                r_pv1 <= r_pv0;
                r_pc1 <= r_pc0;
                r_pv0 <= r_v;
                r_pc0 <= r_c;
                if (r_end) begin
                    r_seen <= 2'd0;
                end else if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

    // Item fields, work plan and operands.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_v        <= i_sample_value;
                    r_c        <= i_coordinate;
                    r_end      <= i_line_end;
                    r_live     <= a_live;
                    r_copies   <= a_copies;
                    r_last_fin <= a_last_fin;
                    r_has_b    <= a_has_b;
                    r_use_div  <= a_use_div;
                    r_sq       <= a_sq;
                    r_sel1     <= a_sel1;
                end
            end
            S_PREP: begin
                r_num <= num_n;
                r_den <= den_n;
                r_res <= '0;
                r_zf  <= 1'b0;
            end
            S_WAIT: begin
                if (div_sts.done) begin
                    r_res <= div_quot;
                    r_zf  <= div_sts.zero;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    // Backward difference for the line's final point follows.
                    if ((r_copies == 2'd1) && r_has_b) begin
                        r_use_div  <= r_live;
                        r_sq       <= 1'b0;
                        r_sel1     <= 1'b0;
                        r_copies   <= 2'd1;
                        r_last_fin <= 1'b1;
                        r_has_b    <= 1'b0;
                    end else begin
                        r_copies <= r_copies - 2'd1;
                    end
                end
            end
            default: begin
                r_copies <= r_copies;
            end
        endcase
    end

    fdd_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    fdd_out_stage #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (emit_load),
        .i_derivative   (r_res),
        .i_last         (emit_last),
        .i_zero         (r_zf),
        .o_free         (out_free),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_derivative   (o_derivative),
        .o_last_result  (o_last_result),
        .o_zero_divisor (o_zero_divisor)
    );

endmodule

@@ hdl/fdd_checker.sv @@
module fdd_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [VALUE_WIDTH-1:0] o_derivative,
    input logic                   o_last_result,
    input logic                   o_zero_divisor
);

    // A result waiting under stall stays in place unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_derivative)
                                  && $stable(o_last_result) && $stable(o_zero_divisor)))
        else $error("result changed while stalled");

    // The block works on one item at a time, so it stalls right after an item is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item taken before the first was finished");

    // A zero spacing always forces a zero derivative.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_divisor) |-> (o_derivative == '0))
        else $error("zero spacing with a nonzero derivative");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind finite_difference_derivative_line_top fdd_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_fdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_derivative   (o_derivative),
    .o_last_result  (o_last_result),
    .o_zero_divisor (o_zero_divisor)
);
